/* src/trivium_stream_cipher_core_defines.svh */
// ----------------------------------------------------------------------------
// Trivium stream cipher core - assertion macros
// Concurrent check macros; they compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef TRIVIUM_STREAM_CIPHER_CORE_DEFINES_SVH
`define TRIVIUM_STREAM_CIPHER_CORE_DEFINES_SVH

`ifndef SYNTH
// cond must hold at every clock edge outside reset
`define TSC_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("tsc check failed");
// cons must hold in the cycle after ante
`define TSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsc sequence check failed");
`else
`define TSC_ASSERT(label, cond)
`define TSC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* src/tsc_pkg.sv */
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared types, constants and the unrolled Trivium round function.
// ----------------------------------------------------------------------------
`default_nettype none

package tsc_pkg;

    localparam int STATE_W = 288;
    localparam int KEY_W   = 80;
    localparam int IV_POS  = 93;   // s94 sits at bit 93
    localparam int ROUNDS_PER_STEP = 8;

    localparam logic [1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [1:0] REG_KEY_HIGH = 2'd1;
    localparam logic [1:0] REG_IV_LOW   = 2'd2;
    localparam logic [1:0] REG_IV_HIGH  = 2'd3;

    typedef enum logic [1:0] {
        S_PENDING,  // init pending, waiting for first byte of a message
        S_WARM,     // warm-up rounds
        S_EMIT,     // deliver the byte held during warm-up
        S_RUN       // one byte per cycle while the output register can take a result
    } ctrl_state_t;

    typedef struct packed {
        logic load;       // capture input transaction, load key/IV into state
        logic step;       // advance state by eight rounds, no output
        logic emit_hold;  // eight rounds, output from held byte
        logic emit_in;    // eight rounds, output from input byte
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;   // output register can take a result this cycle
        logic hold_last;  // held byte closes its message
    } dp_status_t;

    typedef struct packed {
        logic [STATE_W-1:0] st;
        logic [7:0]         ks;
    } rounds_t;

    // Eight Trivium rounds; bit s(k) lives at index k-1.
    // Keystream bit of round i goes to ks[i].
    function automatic rounds_t trv_rounds8(input logic [STATE_W-1:0] s);
        rounds_t            r;
        logic [STATE_W-1:0] st;
        logic               t1;
        logic               t2;
        logic               t3;
        logic               a;
        logic               b;
        logic               c;
        st   = s;
        r.ks = '0;
        for (int i = 0; i < ROUNDS_PER_STEP; i++)
        begin
            t1 = st[65] ^ st[92];
            t2 = st[161] ^ st[176];
            t3 = st[242] ^ st[287];
            r.ks[i] = t1 ^ t2 ^ t3;
            a  = t1 ^ (st[90] & st[91]) ^ st[170];
            b  = t2 ^ (st[174] & st[175]) ^ st[263];
            c  = t3 ^ (st[285] & st[286]) ^ st[68];
            st = {st[STATE_W-2:0], c};
            st[93]  = a;
            st[177] = b;
        end
        r.st = st;
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/tsc_ctrl.sv */
// ----------------------------------------------------------------------------
// tsc_ctrl
// Sequencer: message init, warm-up count and input/output flow control.
// ----------------------------------------------------------------------------
`default_nettype none
`include "trivium_stream_cipher_core_defines.svh"

module tsc_ctrl
    import tsc_pkg::*;
#(
    parameter int WARMUP_ROUNDS = 1152
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       last_byte,
    output logic            in_stall,
    output dp_cmd_t         cmd,
    input  wire dp_status_t status
);

    localparam int WARM_STEPS = WARMUP_ROUNDS / ROUNDS_PER_STEP;
    localparam int CNT_W      = (WARM_STEPS > 1) ? $clog2(WARM_STEPS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WARM_STEPS - 1);

    ctrl_state_t      state_reg;
    ctrl_state_t      state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_PENDING;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_PENDING:
            begin
                cnt_next = '0;
                if (in_valid)
                    state_next = S_WARM;
            end
            S_WARM:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                    state_next = status.hold_last ? S_PENDING : S_RUN;
            end
            S_RUN:
            begin
                if (in_valid && status.out_free && last_byte)
                    state_next = S_PENDING;
            end
            default:
            begin
                state_next = S_PENDING;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_stall = 1'b1;
        cmd      = '0;
        case (state_reg)
            S_PENDING:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            S_WARM:
            begin
                cmd.step = 1'b1;
            end
            S_EMIT:
            begin
                cmd.emit_hold = status.out_free;
            end
            S_RUN:
            begin
                in_stall    = !status.out_free;
                cmd.emit_in = in_valid && status.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    `TSC_ASSERT(a_emit_needs_room, (cmd.emit_in || cmd.emit_hold) |-> status.out_free)
    `TSC_ASSERT_NEXT(a_load_starts_warm, cmd.load, (state_reg == S_WARM) && (cnt_reg == '0))
    `TSC_ASSERT_NEXT(a_warm_ends, (state_reg == S_WARM) && (cnt_reg == CNT_LAST),
                     state_reg == S_EMIT)
    `TSC_ASSERT_NEXT(a_last_reinit, cmd.emit_in && last_byte, state_reg == S_PENDING)

endmodule

`default_nettype wire

/* src/tsc_datapath.sv */
// ----------------------------------------------------------------------------
// tsc_datapath
// Key/IV registers, 288-bit cipher state, eight-round unit and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tsc_datapath
    import tsc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    input  wire dp_cmd_t     cmd,
    output dp_status_t       status,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic             out_last
);

    logic [63:0]        key_low_reg;
    logic [15:0]        key_high_reg;
    logic [63:0]        iv_low_reg;
    logic [15:0]        iv_high_reg;
    logic [STATE_W-1:0] state_reg;
    logic [STATE_W-1:0] state_next;
    logic [7:0]         hold_byte_reg;
    logic               hold_last_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [7:0]         out_byte_reg;
    logic [7:0]         out_byte_next;
    logic               out_last_reg;
    logic               out_last_next;
    logic [STATE_W-1:0] init_state;
    rounds_t            rnd;
    logic               emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            iv_low_reg   <= '0;
            iv_high_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_KEY_LOW:  key_low_reg  <= cfg_data;
                REG_KEY_HIGH: key_high_reg <= cfg_data[15:0];
                REG_IV_LOW:   iv_low_reg   <= cfg_data;
                REG_IV_HIGH:  iv_high_reg  <= cfg_data[15:0];
                default:      key_low_reg  <= key_low_reg;
            endcase
        end
    end

    // key at s1..s80, IV at s94..s173, ones at s286..s288
    always_comb
    begin
        init_state = '0;
        init_state[KEY_W-1:0]                 = {key_high_reg, key_low_reg};
        init_state[IV_POS+KEY_W-1:IV_POS]     = {iv_high_reg, iv_low_reg};
        init_state[STATE_W-1:STATE_W-3]       = 3'b111;
    end

    assign rnd  = trv_rounds8(state_reg);
    assign emit = cmd.emit_in || cmd.emit_hold;

    always_comb
    begin
        state_next = state_reg;
        if (cmd.load)
            state_next = init_state;
        else if (cmd.step || emit)
            state_next = rnd.st;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (cmd.emit_in)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = data_byte ^ rnd.ks;
            out_last_next  = last_byte;
        end
        else if (cmd.emit_hold)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = hold_byte_reg ^ rnd.ks;
            out_last_next  = hold_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        state_reg    <= state_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        if (cmd.load)
        begin
            hold_byte_reg <= data_byte;
            hold_last_reg <= last_byte;
        end
    end

    assign status.out_free  = !out_valid_reg || !out_stall;
    assign status.hold_last = hold_last_reg;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

/* src/trivium_stream_cipher_core.sv */
// ----------------------------------------------------------------------------
// trivium_stream_cipher_core
// Trivium (80-bit key, 80-bit IV) byte stream encrypt/decrypt engine.
// ----------------------------------------------------------------------------
// Each input transaction carries one byte; the core returns that byte XORed
// with the next eight keystream bits (first keystream bit in bit 0) and a
// copy of its last flag. The first transaction of a message (after reset or
// after a transaction with last_byte set) is taken at once and held while
// the state is loaded from the key/IV registers and warmed up: WARMUP_ROUNDS
// rounds at eight rounds per clock, after which the emit state delivers its
// result. After that one byte is accepted per cycle as long as the output
// register can take a result; the eight-round unit on the 288-bit state
// register sets that rate.
// A registered output stage lets the next byte in while the current result
// is still waiting, as long as out_stall is low. Key and IV registers are
// written through cfg_write/cfg_index/cfg_data (index 0 key_low, 1 key_high,
// 2 iv_low, 3 iv_high; high halves keep data bits 15:0) and are read only
// when a new message starts.
// ----------------------------------------------------------------------------
`default_nettype none

module trivium_stream_cipher_core
    import tsc_pkg::*;
#(
    parameter int WARMUP_ROUNDS = 1152
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write port
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    // input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    // output channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic             out_last
);

    dp_cmd_t    cmd;     // controller -> datapath
    dp_status_t status;  // datapath -> controller

    // Sequencer: pending/warm-up/emit/run, warm-up counter.
    tsc_ctrl #(
        .WARMUP_ROUNDS (WARMUP_ROUNDS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last_byte (last_byte),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .status    (status)
    );

    // State register, round unit, key/IV registers and result register.
    tsc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

endmodule

`default_nettype wire
